### rtl/dmxrdm_pkg.sv
package dmxrdm_pkg;

   // Device window and universe geometry.
   localparam int WINDOW_SLOTS     = 4;
   localparam int UNIVERSE_SLOTS   = 512;
   localparam int RDM_BUFFER_BYTES = 64;
   localparam int START_MAX        = UNIVERSE_SLOTS - WINDOW_SLOTS;

   // Field widths.
   localparam int ADDR_W      = 9;
   localparam int UID_W       = 48;
   localparam int COUNT_W     = 16;
   localparam int SUM_W       = 16;
   localparam int SLOT_IDX_W  = 2;
   localparam int RDM_IDX_W   = 6;
   localparam int CSR_IDX_W   = 2;
   localparam int REQ_DATA_W  = 16;
   localparam int REQ_USER_W  = 2;
   localparam int RSP_DATA_W  = 32;

   // Start codes.
   localparam logic [7:0] SC_DMX = 8'h00;
   localparam logic [7:0] SC_RDM = 8'hCC;
   localparam logic [7:0] SC_SUB = 8'h01;

   // Register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_START_ADDRESS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_OWN_UID       = 2'd1;

   typedef enum logic [1:0] {
      MODE_BYTE      = 2'd0,
      MODE_MIN_BREAK = 2'd1,
      MODE_EDGE      = 2'd2,
      MODE_ACK       = 2'd3
   } mode_type;

   typedef enum logic [2:0] {
      ERR_NONE         = 3'd0,
      ERR_OVERRUN      = 3'd1,
      ERR_FRAMING      = 3'd2,
      ERR_BAD_START    = 3'd3,
      ERR_DMX_PENDING  = 3'd4,
      ERR_BAD_SUB      = 3'd5,
      ERR_BAD_CHECKSUM = 3'd6,
      ERR_RDM_OVERRUN  = 3'd7
   } err_type;

   typedef enum logic [5:0] {
      PH_WAIT   = 6'b000001,
      PH_VERIFY = 6'b000010,
      PH_LEN_OK = 6'b000100,
      PH_START  = 6'b001000,
      PH_DMX    = 6'b010000,
      PH_RDM    = 6'b100000
   } phase_type;

   typedef struct packed {
      mode_type   mode;
      logic [7:0] rx_byte;
      logic       framing_error;
      logic       overrun_error;
      logic       clear_dmx_ready;
      logic       clear_rdm_ready;
   } in_item_type;

   typedef struct packed {
      err_type               error_code;
      logic                  slot_write;
      logic [SLOT_IDX_W-1:0] slot_index;
      logic [7:0]            slot_value;
      logic                  rdm_write;
      logic [RDM_IDX_W-1:0]  rdm_index;
      logic [7:0]            rdm_byte;
      logic                  dmx_ready;
      logic                  rdm_ready;
   } out_item_type;

endpackage

### rtl/dmxrdm_cfg.sv
module dmxrdm_cfg
   import dmxrdm_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [UID_W-1:0]     csr_wdata,
   output logic [ADDR_W-1:0]    start_address,
   output logic [UID_W-1:0]     own_uid
);

   logic [ADDR_W-1:0] start_ff, start_in;
   logic [UID_W-1:0]  uid_ff, uid_in;
   logic [ADDR_W-1:0] wr_addr;

   // An out-of-range start address falls back to the first slot.
   always_comb begin
      wr_addr  = csr_wdata[ADDR_W-1:0];
      start_in = start_ff;
      uid_in   = uid_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_START_ADDRESS: begin
               if (wr_addr == '0 || wr_addr > ADDR_W'(START_MAX)) begin
                  start_in = ADDR_W'(1);
               end else begin
                  start_in = wr_addr;
               end
            end
            CSR_OWN_UID: uid_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff <= ADDR_W'(1);
         uid_ff   <= '0;
      end else begin
         start_ff <= start_in;
         uid_ff   <= uid_in;
      end
   end

   assign start_address = start_ff;
   assign own_uid       = uid_ff;

endmodule

### rtl/dmxrdm_core.sv
module dmxrdm_core
   import dmxrdm_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              step_en,
   input  in_item_type       item,
   input  logic [ADDR_W-1:0] start_address,
   input  logic [UID_W-1:0]  own_uid,
   output out_item_type      result
);

   phase_type            phase_ff, phase_in;
   logic [COUNT_W-1:0]   count_ff, count_in;
   logic [7:0]           len_ff, len_in;
   logic [SUM_W-1:0]     sum_ff, sum_in;
   logic [7:0]           hi_ff, hi_in;
   logic                 dmx_ff, dmx_in;
   logic                 rdm_ff, rdm_in;

   logic [7:0]           b;
   logic [ADDR_W:0]      last_slot;
   logic [COUNT_W-1:0]   slot_off;
   logic                 in_window;
   logic [7:0]           uid_sel;
   logic [ADDR_W-1:0]    len_plus;
   logic                 inc;

   // Window bounds and the expected UID byte for the current position.
   always_comb begin
      b         = item.rx_byte;
      last_slot = {1'b0, start_address} + (ADDR_W + 1)'(WINDOW_SLOTS - 1);
      slot_off  = count_ff - COUNT_W'(start_address);
      in_window = (count_ff >= COUNT_W'(start_address)) &&
                  (count_ff <= COUNT_W'(last_slot));
      len_plus  = {1'b0, len_ff} + ADDR_W'(1);
      case (count_ff[3:0])
         4'd3:    uid_sel = own_uid[47:40];
         4'd4:    uid_sel = own_uid[39:32];
         4'd5:    uid_sel = own_uid[31:24];
         4'd6:    uid_sel = own_uid[23:16];
         4'd7:    uid_sel = own_uid[15:8];
         4'd8:    uid_sel = own_uid[7:0];
         default: uid_sel = '0;
      endcase
   end

   // Per-word state update and result.
   always_comb begin
      phase_in = phase_ff;
      count_in = count_ff;
      len_in   = len_ff;
      sum_in   = sum_ff;
      hi_in    = hi_ff;
      dmx_in   = dmx_ff;
      rdm_in   = rdm_ff;
      result   = '0;
      inc      = 1'b0;

      case (item.mode)
         MODE_BYTE: begin
            if (item.framing_error) begin
               // A zero byte with a framing error is the start of a break.
               if (b == 8'h00) begin
                  phase_in = PH_VERIFY;
                  count_in = '0;
               end else begin
                  phase_in          = PH_WAIT;
                  result.error_code = ERR_FRAMING;
               end
            end else if (item.overrun_error) begin
               phase_in          = PH_WAIT;
               result.error_code = ERR_OVERRUN;
            end else begin
               inc = 1'b1;
               case (phase_ff)
                  PH_START: begin
                     if (b == SC_DMX) begin
                        if (dmx_ff) begin
                           phase_in          = PH_WAIT;
                           result.error_code = ERR_DMX_PENDING;
                           inc               = 1'b0;
                        end else begin
                           phase_in = PH_DMX;
                        end
                     end else if (b == SC_RDM) begin
                        if (rdm_ff) begin
                           phase_in          = PH_WAIT;
                           result.error_code = ERR_RDM_OVERRUN;
                           inc               = 1'b0;
                        end else begin
                           // The start code opens a fresh sum.
                           phase_in         = PH_RDM;
                           sum_in           = {8'h00, b};
                           result.rdm_write = 1'b1;
                           result.rdm_index = count_ff[RDM_IDX_W-1:0];
                           result.rdm_byte  = b;
                        end
                     end else begin
                        phase_in          = PH_WAIT;
                        result.error_code = ERR_BAD_START;
                        inc               = 1'b0;
                     end
                  end
                  PH_DMX: begin
                     if (in_window) begin
                        result.slot_write = 1'b1;
                        result.slot_index = slot_off[SLOT_IDX_W-1:0];
                        result.slot_value = b;
                        if (count_ff == COUNT_W'(last_slot)) begin
                           dmx_in   = 1'b1;
                           phase_in = PH_WAIT;
                        end
                     end
                  end
                  PH_RDM: begin
                     if (count_ff <= COUNT_W'(8)) begin
                        // Header: sub start code, length, destination UID.
                        if (count_ff == COUNT_W'(1) && b != SC_SUB) begin
                           phase_in          = PH_WAIT;
                           result.error_code = ERR_BAD_SUB;
                        end else if (count_ff == COUNT_W'(2) &&
                                     b > 8'(RDM_BUFFER_BYTES)) begin
                           len_in            = b;
                           phase_in          = PH_WAIT;
                           result.error_code = ERR_RDM_OVERRUN;
                        end else if (count_ff >= COUNT_W'(3) && uid_sel != b) begin
                           phase_in = PH_WAIT;
                        end else begin
                           if (count_ff == COUNT_W'(2)) begin
                              len_in = b;
                           end
                           result.rdm_write = 1'b1;
                           result.rdm_index = count_ff[RDM_IDX_W-1:0];
                           result.rdm_byte  = b;
                           sum_in           = sum_ff + {8'h00, b};
                        end
                     end else if (count_ff < COUNT_W'(len_ff)) begin
                        result.rdm_write = 1'b1;
                        result.rdm_index = count_ff[RDM_IDX_W-1:0];
                        result.rdm_byte  = b;
                        sum_in           = sum_ff + {8'h00, b};
                     end else if (count_ff == COUNT_W'(len_ff)) begin
                        hi_in = b;
                     end else if (count_ff == COUNT_W'(len_plus)) begin
                        phase_in = PH_WAIT;
                        if ({hi_ff, b} == sum_ff) begin
                           rdm_in = 1'b1;
                        end else begin
                           result.error_code = ERR_BAD_CHECKSUM;
                        end
                     end
                  end
                  default: ;
               endcase
               if (inc) begin
                  count_in = count_ff + COUNT_W'(1);
               end
            end
         end
         MODE_MIN_BREAK: begin
            if (phase_ff == PH_VERIFY) begin
               phase_in = PH_LEN_OK;
            end
         end
         MODE_EDGE: begin
            // An edge before the minimum break time aborts the break.
            if (phase_ff == PH_LEN_OK) begin
               phase_in = PH_START;
            end else if (phase_ff == PH_VERIFY) begin
               phase_in = PH_WAIT;
            end
         end
         MODE_ACK: begin
            if (item.clear_dmx_ready) begin
               dmx_in = 1'b0;
            end
            if (item.clear_rdm_ready) begin
               rdm_in = 1'b0;
            end
         end
         default: ;
      endcase

      result.dmx_ready = dmx_in;
      result.rdm_ready = rdm_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_WAIT;
         count_ff <= '0;
         len_ff   <= '0;
         sum_ff   <= '0;
         hi_ff    <= '0;
         dmx_ff   <= 1'b0;
         rdm_ff   <= 1'b0;
      end else if (step_en) begin
         phase_ff <= phase_in;
         count_ff <= count_in;
         len_ff   <= len_in;
         sum_ff   <= sum_in;
         hi_ff    <= hi_in;
         dmx_ff   <= dmx_in;
         rdm_ff   <= rdm_in;
      end
   end

endmodule

### rtl/dmx512_rdm_receiver.sv
// DMX512 / RDM receive front end.
// The req_ channel carries one UART byte or line event per word: req_tuser
// holds the event kind, req_tdata the byte and its UART flags. Breaks, start
// codes, DMX slots of the device window and RDM packet headers are decoded
// here. Every accepted word yields exactly one rsp_ word with the error code,
// an optional slot write, an optional RDM buffer write and both ready flags.
// The csr_ port writes the start address (index 0) and the own UID
// (index 1); write it only while no words are in flight.
// An accepted word goes into the input register, is decoded and lands in
// the output register, which drives rsp_tvalid, as soon as that register is
// free. Throughput is one word per cycle while rsp_tready stays high; the
// state update between the input and output registers is combinational.
// When the rsp_ side stalls, the output register holds its word and the input
// register still takes one more word; req_tready then drops until rsp_tready
// returns. Reset (synchronous) empties both registers, returns the receiver
// to waiting for a break, clears both ready flags, sets the start address to
// 1 and the UID to zero.
module dmx512_rdm_receiver
   import dmxrdm_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // rx_byte[7:0], framing_error[8], overrun_error[9], clear_dmx_ready[10],
   // clear_rdm_ready[11], zero fill [15:12]
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // mode[1:0]
   input  logic [REQ_USER_W-1:0] req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // error_code[2:0], slot_write[3], slot_index[5:4], slot_value[13:6],
   // rdm_write[14], rdm_index[20:15], rdm_byte[28:21], dmx_ready[29],
   // rdm_ready[30], zero fill [31]
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [UID_W-1:0]      csr_wdata
);

   logic              in_valid_ff, in_valid_in;
   in_item_type       in_item_ff, in_item_in;
   logic              out_valid_ff, out_valid_in;
   out_item_type      out_item_ff;
   out_item_type      step_result;
   logic              advance;
   logic              step_en;
   logic [ADDR_W-1:0] start_address;
   logic [UID_W-1:0]  own_uid;

   dmxrdm_cfg u_cfg (
      .clock         (clock),
      .reset         (reset),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .start_address (start_address),
      .own_uid       (own_uid)
   );

   dmxrdm_core u_core (
      .clock         (clock),
      .reset         (reset),
      .step_en       (step_en),
      .item          (in_item_ff),
      .start_address (start_address),
      .own_uid       (own_uid),
      .result        (step_result)
   );

   // Handshake: the output register frees up when empty or being taken.
   assign advance    = !out_valid_ff || rsp_tready;
   assign step_en    = in_valid_ff && advance;
   assign req_tready = !in_valid_ff || advance;

   // Unpack the request word.
   always_comb begin
      in_item_in.mode            = mode_type'(req_tuser);
      in_item_in.rx_byte         = req_tdata[7:0];
      in_item_in.framing_error   = req_tdata[8];
      in_item_in.overrun_error   = req_tdata[9];
      in_item_in.clear_dmx_ready = req_tdata[10];
      in_item_in.clear_rdm_ready = req_tdata[11];
      in_valid_in  = req_tready ? req_tvalid : in_valid_ff;
      out_valid_in = advance ? in_valid_ff : out_valid_ff;
   end

   // Input and output valid flags.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_item_ff <= in_item_in;
      end
      if (step_en) begin
         out_item_ff <= step_result;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {1'b0,
                        out_item_ff.rdm_ready,
                        out_item_ff.dmx_ready,
                        out_item_ff.rdm_byte,
                        out_item_ff.rdm_index,
                        out_item_ff.rdm_write,
                        out_item_ff.slot_value,
                        out_item_ff.slot_index,
                        out_item_ff.slot_write,
                        out_item_ff.error_code};

   // A word never writes both a slot and an RDM byte.
   a_one_write: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(out_item_ff.slot_write && out_item_ff.rdm_write))
      else $error("slot and RDM write in the same word");

   // An error word carries no write.
   a_err_no_write: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && out_item_ff.error_code != ERR_NONE) |->
         (!out_item_ff.slot_write && !out_item_ff.rdm_write))
      else $error("write reported together with an error");

   // A decoded word shows up on the result side in the next cycle.
   a_step_out: assert property (@(posedge clock) disable iff (reset)
      step_en |=> rsp_tvalid)
      else $error("decoded word lost");

endmodule
